// ===== rtl/hasu_pkg.sv =====
// shared types, constants and defaults of the assignment solver
`default_nettype none
package hasu_pkg;

  localparam int MAX_DIM_DEF    = 16;
  localparam int COST_WIDTH_DEF = 16;
  localparam int WORK_W         = 24;
  localparam int TOT_W          = 20;
  localparam int DIM_W          = 5;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  localparam logic [WORK_W-1:0] WORK_MAX  = {WORK_W{1'b1}};
  localparam logic [TOT_W-1:0]  TOT_MAX   = {TOT_W{1'b1}};
  localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(16);

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMIN,
    S_RSUB,
    S_STAR,
    S_COVER,
    S_ZSRCH,
    S_ZDEC,
    S_AMIN,
    S_ADEC,
    S_AADJ,
    S_AUG,
    S_TOTAL,
    S_EMIT
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/hasu_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module hasu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/hasu_cfg.sv =====
// apb register block holding the matrix dimensions
`default_nettype none
module hasu_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hasu_pkg::APB_AW-1:0]   paddr,
  input  wire logic [hasu_pkg::APB_DW-1:0]   pwdata,
  output logic      [hasu_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output hasu_pkg::cfg_t                     cfg_o
);

  hasu_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic           sel_reg;

  assign pready  = 1'b1;
  assign sel_reg = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel_reg)
        hasu_pkg::REG_ROWS: cfg_d.rows = pwdata[hasu_pkg::DIM_W-1:0];
        hasu_pkg::REG_COLS: cfg_d.cols = pwdata[hasu_pkg::DIM_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel_reg)
      hasu_pkg::REG_ROWS: prdata = hasu_pkg::APB_DW'(cfg_q.rows);
      hasu_pkg::REG_COLS: prdata = hasu_pkg::APB_DW'(cfg_q.cols);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows <= hasu_pkg::DIM_RESET;
      cfg_q.cols <= hasu_pkg::DIM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/hungarian_assignment_solver_unit.sv =====
// top level of the minimum-cost assignment solver
`default_nettype none
// Cost entries are taken one per cycle into the cost memory while idle; the entry with
// tlast set starts a solve over the rows_in_use x cols_in_use corner and the block takes
// no request until every column in use has been reported. A full pass walks the work
// memory one entry a cycle, a short pass one row or column: reduction takes two short
// passes per row (or column), starring one full pass, every zero search one full pass and
// a decision state, every adjustment two full passes and a decision state, each cover
// check and each augmenting step a single state, and the final cost sum one pass over the
// columns. The number of searches depends on the costs (of the order of n^2 for an n x n
// matrix). Results then leave one per cycle, column 0 first, unless held off by tready.
module hungarian_assignment_solver_unit #(
  parameter int MAX_DIM    = hasu_pkg::MAX_DIM_DEF,
  parameter int COST_WIDTH = hasu_pkg::COST_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // cost_value[15:0], row_index[19:16], col_index[23:20]
  input  wire logic [23:0]                 s_axis_tdata,
  input  wire logic                        s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // column[3:0], assigned_row[7:4], assigned[8], total_cost[28:9], zero[31:29]
  output logic      [31:0]                 m_axis_tdata,
  output logic                             m_axis_tlast,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hasu_pkg::APB_AW-1:0] paddr,
  input  wire logic [hasu_pkg::APB_DW-1:0] pwdata,
  output logic      [hasu_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);

  localparam int IW    = $clog2(MAX_DIM);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int WW    = hasu_pkg::WORK_W;
  localparam int TW    = hasu_pkg::TOT_W;
  localparam int SUM_W = ((COST_WIDTH > TW) ? COST_WIDTH : TW) + 1;

  hasu_pkg::cfg_t cfg;

  hasu_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  function automatic logic [NW-1:0] clamp_dim(input logic [hasu_pkg::DIM_W-1:0] v);
    logic [NW-1:0] res;
    if (v == '0) begin
      res = NW'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = NW'(MAX_DIM);
    end else begin
      res = NW'(v);
    end
    return res;
  endfunction

  logic [NW-1:0] nr, nc, nrm1, ncm1, need;
  logic          by_row;

  assign nr     = clamp_dim(cfg.rows);
  assign nc     = clamp_dim(cfg.cols);
  assign nrm1   = nr - NW'(1);
  assign ncm1   = nc - NW'(1);
  assign need   = (nr < nc) ? nr : nc;
  assign by_row = (nr <= nc);

  hasu_pkg::state_e state_q, state_d;

  logic [IW-1:0]   ia_q, ia_d, ib_q, ib_d;
  logic            iss_q, iss_d;
  logic            pv_q, pv_d, plast_q, plast_d;
  logic [IW-1:0]   pr_q, pr_d, pc_q, pc_d;
  logic [WW-1:0]   mn_q, mn_d;
  logic            found_q, found_d;
  logic            zhit_q, zhit_d, zlock_q, zlock_d;
  logic [IW-1:0]   zr_q, zr_d, zc_q, zc_d;
  logic [TW-1:0]   acc_q, acc_d;
  logic [IW-1:0]   oc_q, oc_d;
  logic [MAX_DIM-1:0] star_v_q, star_v_d, prime_v_q, prime_v_d;
  logic [MAX_DIM-1:0] row_cov_q, row_cov_d, col_cov_q, col_cov_d;
  logic [IW-1:0]   star_col_q [MAX_DIM];
  logic [IW-1:0]   star_col_d [MAX_DIM];
  logic [IW-1:0]   prime_col_q [MAX_DIM];
  logic [IW-1:0]   prime_col_d [MAX_DIM];
  logic            m_valid_q, m_valid_d, m_last_q, m_last_d;
  logic [31:0]     m_data_q, m_data_d;

  logic [MAX_DIM-1:0] colstar_v;
  logic [IW-1:0]      colstar_row [MAX_DIM];

  always_comb begin
    for (int c = 0; c < MAX_DIM; c++) begin
      colstar_v[c]   = 1'b0;
      colstar_row[c] = '0;
      for (int r = 0; r < MAX_DIM; r++) begin
        if (star_v_q[r] && (star_col_q[r] == IW'(c))) begin
          colstar_v[c]   = 1'b1;
          colstar_row[c] = IW'(r);
        end
      end
    end
  end

  // scan address generation
  logic          cm, full_scan;
  logic [NW-1:0] outer_m1, inner_m1;
  logic [IW-1:0] r_iss, c_iss, row_addr;
  logic          end_inner, end_outer;

  assign cm        = ((state_q == hasu_pkg::S_RMIN) || (state_q == hasu_pkg::S_RSUB)) && !by_row;
  assign full_scan = !((state_q == hasu_pkg::S_RMIN) || (state_q == hasu_pkg::S_RSUB) ||
                       (state_q == hasu_pkg::S_TOTAL));
  assign outer_m1  = cm ? ncm1 : nrm1;
  assign inner_m1  = cm ? nrm1 : ncm1;
  assign r_iss     = cm ? ib_q : ia_q;
  assign c_iss     = cm ? ia_q : ib_q;
  assign row_addr  = (state_q == hasu_pkg::S_TOTAL) ? colstar_row[ib_q] : r_iss;
  assign end_inner = (NW'(ib_q) == inner_m1);
  assign end_outer = (NW'(ia_q) == outer_m1);

  // memories
  logic                  in_acc, in_range;
  logic [IW-1:0]         in_row, in_col;
  logic [COST_WIDTH-1:0] cost_rd;
  logic [WW-1:0]         work_rd, work_wd, cost_ext;
  logic                  work_we;
  logic [WW:0]           adj_sum;

  assign s_axis_tready = (state_q == hasu_pkg::S_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = (int'(s_axis_tdata[19:16]) < MAX_DIM) &&
                    (int'(s_axis_tdata[23:20]) < MAX_DIM);
  assign in_row   = IW'(s_axis_tdata[19:16]);
  assign in_col   = IW'(s_axis_tdata[23:20]);
  assign cost_ext = WW'(cost_rd);

  hasu_ram #(.WIDTH(COST_WIDTH), .DEPTH(DEPTH)) u_cost_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && in_range),
    .waddr_i({in_row, in_col}),
    .wdata_i(COST_WIDTH'(s_axis_tdata[15:0])),
    .raddr_i({row_addr, c_iss}),
    .rdata_o(cost_rd)
  );

  hasu_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_work_ram (
    .clk_i  (clk_i),
    .we_i   (work_we),
    .waddr_i({pr_q, pc_q}),
    .wdata_i(work_wd),
    .raddr_i({r_iss, c_iss}),
    .rdata_o(work_rd)
  );

  assign work_we = pv_q && ((state_q == hasu_pkg::S_RSUB) || (state_q == hasu_pkg::S_AADJ));
  assign adj_sum = {1'b0, work_rd} + {1'b0, mn_q};

  always_comb begin
    if (state_q == hasu_pkg::S_RSUB) begin
      work_wd = cost_ext - mn_q;
    end else if (row_cov_q[pr_q] && col_cov_q[pc_q]) begin
      work_wd = adj_sum[WW] ? hasu_pkg::WORK_MAX : adj_sum[WW-1:0];
    end else if (!row_cov_q[pr_q] && !col_cov_q[pc_q]) begin
      work_wd = (work_rd > mn_q) ? (work_rd - mn_q) : '0;
    end else begin
      work_wd = work_rd;
    end
  end

  logic [SUM_W-1:0] tot_sum;
  logic             zero_hit;
  logic             emit_ok;

  assign tot_sum  = SUM_W'(acc_q) + SUM_W'(cost_rd);
  assign zero_hit = (work_rd == '0) && !row_cov_q[pr_q] && !col_cov_q[pc_q] && !zlock_q;
  assign emit_ok  = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    iss_d       = iss_q;
    pv_d        = 1'b0;
    plast_d     = 1'b0;
    pr_d        = pr_q;
    pc_d        = pc_q;
    mn_d        = mn_q;
    found_d     = found_q;
    zhit_d      = zhit_q;
    zlock_d     = zlock_q;
    zr_d        = zr_q;
    zc_d        = zc_q;
    acc_d       = acc_q;
    oc_d        = oc_q;
    star_v_d    = star_v_q;
    prime_v_d   = prime_v_q;
    row_cov_d   = row_cov_q;
    col_cov_d   = col_cov_q;
    star_col_d  = star_col_q;
    prime_col_d = prime_col_q;
    m_valid_d   = m_valid_q;
    m_last_d    = m_last_q;
    m_data_d    = m_data_q;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (iss_q) begin
      pv_d    = 1'b1;
      pr_d    = r_iss;
      pc_d    = c_iss;
      plast_d = end_inner && (!full_scan || end_outer);
      if (end_inner) begin
        ib_d = '0;
        if (full_scan && !end_outer) begin
          ia_d = ia_q + IW'(1);
        end else begin
          iss_d = 1'b0;
        end
      end else begin
        ib_d = ib_q + IW'(1);
      end
    end

    case (state_q)
      hasu_pkg::S_IDLE: begin
        if (in_acc && s_axis_tlast) begin
          state_d   = hasu_pkg::S_RMIN;
          ia_d      = '0;
          ib_d      = '0;
          iss_d     = 1'b1;
          mn_d      = hasu_pkg::WORK_MAX;
          star_v_d  = '0;
          prime_v_d = '0;
          row_cov_d = '0;
          col_cov_d = '0;
        end
      end
      hasu_pkg::S_RMIN: begin
        if (pv_q) begin
          if (cost_ext < mn_q) begin
            mn_d = cost_ext;
          end
          if (plast_q) begin
            state_d = hasu_pkg::S_RSUB;
            iss_d   = 1'b1;
            ib_d    = '0;
          end
        end
      end
      hasu_pkg::S_RSUB: begin
        if (pv_q && plast_q) begin
          iss_d = 1'b1;
          ib_d  = '0;
          if (end_outer) begin
            state_d = hasu_pkg::S_STAR;
            ia_d    = '0;
          end else begin
            state_d = hasu_pkg::S_RMIN;
            ia_d    = ia_q + IW'(1);
            mn_d    = hasu_pkg::WORK_MAX;
          end
        end
      end
      hasu_pkg::S_STAR: begin
        if (pv_q) begin
          if ((work_rd == '0) && !col_cov_q[pc_q] && !star_v_q[pr_q]) begin
            star_v_d[pr_q]   = 1'b1;
            star_col_d[pr_q] = pc_q;
            col_cov_d[pc_q]  = 1'b1;
          end
          if (plast_q) begin
            col_cov_d = '0;
            row_cov_d = '0;
            state_d   = hasu_pkg::S_COVER;
          end
        end
      end
      hasu_pkg::S_COVER: begin
        iss_d = 1'b1;
        ia_d  = '0;
        ib_d  = '0;
        if (NW'($countones(star_v_q)) >= need) begin
          state_d = hasu_pkg::S_TOTAL;
          acc_d   = '0;
        end else begin
          state_d   = hasu_pkg::S_ZSRCH;
          col_cov_d = colstar_v;
          zhit_d    = 1'b0;
          zlock_d   = 1'b0;
        end
      end
      hasu_pkg::S_ZSRCH: begin
        if (pv_q) begin
          if (zero_hit) begin
            zhit_d = 1'b1;
            zr_d   = pr_q;
            zc_d   = pc_q;
          end
          if (!zlock_q && (NW'(pc_q) == ncm1) && (zhit_q || zero_hit)) begin
            zlock_d = 1'b1;
          end
          if (plast_q) begin
            state_d = hasu_pkg::S_ZDEC;
          end
        end
      end
      hasu_pkg::S_ZDEC: begin
        if (!zhit_q) begin
          state_d = hasu_pkg::S_AMIN;
          iss_d   = 1'b1;
          ia_d    = '0;
          ib_d    = '0;
          mn_d    = hasu_pkg::WORK_MAX;
          found_d = 1'b0;
        end else begin
          prime_v_d[zr_q]   = 1'b1;
          prime_col_d[zr_q] = zc_q;
          if (star_v_q[zr_q]) begin
            row_cov_d[zr_q]             = 1'b1;
            col_cov_d[star_col_q[zr_q]] = 1'b0;
            state_d = hasu_pkg::S_ZSRCH;
            iss_d   = 1'b1;
            ia_d    = '0;
            ib_d    = '0;
            zhit_d  = 1'b0;
            zlock_d = 1'b0;
          end else begin
            state_d = hasu_pkg::S_AUG;
          end
        end
      end
      hasu_pkg::S_AMIN: begin
        if (pv_q) begin
          if (!row_cov_q[pr_q] && !col_cov_q[pc_q] && (work_rd <= mn_q)) begin
            mn_d    = work_rd;
            found_d = 1'b1;
          end
          if (plast_q) begin
            state_d = hasu_pkg::S_ADEC;
          end
        end
      end
      hasu_pkg::S_ADEC: begin
        iss_d = 1'b1;
        ia_d  = '0;
        ib_d  = '0;
        if (!found_q || (mn_q == '0)) begin
          state_d = hasu_pkg::S_TOTAL;
          acc_d   = '0;
        end else begin
          state_d = hasu_pkg::S_AADJ;
        end
      end
      hasu_pkg::S_AADJ: begin
        if (pv_q && plast_q) begin
          state_d = hasu_pkg::S_ZSRCH;
          iss_d   = 1'b1;
          ia_d    = '0;
          ib_d    = '0;
          zhit_d  = 1'b0;
          zlock_d = 1'b0;
        end
      end
      hasu_pkg::S_AUG: begin
        star_v_d[zr_q]   = 1'b1;
        star_col_d[zr_q] = zc_q;
        if (colstar_v[zc_q] && prime_v_q[colstar_row[zc_q]]) begin
          zr_d = colstar_row[zc_q];
          zc_d = prime_col_q[colstar_row[zc_q]];
        end else begin
          row_cov_d = '0;
          col_cov_d = '0;
          prime_v_d = '0;
          state_d   = hasu_pkg::S_COVER;
        end
      end
      hasu_pkg::S_TOTAL: begin
        if (pv_q) begin
          if (colstar_v[pc_q]) begin
            acc_d = (tot_sum > SUM_W'(hasu_pkg::TOT_MAX)) ? hasu_pkg::TOT_MAX : TW'(tot_sum);
          end
          if (plast_q) begin
            state_d = hasu_pkg::S_EMIT;
            oc_d    = '0;
          end
        end
      end
      hasu_pkg::S_EMIT: begin
        if (emit_ok) begin
          m_valid_d = 1'b1;
          m_last_d  = (NW'(oc_q) == ncm1);
          m_data_d  = {3'b000, acc_q, colstar_v[oc_q],
                       4'(colstar_v[oc_q] ? colstar_row[oc_q] : '0), 4'(oc_q)};
          if (NW'(oc_q) == ncm1) begin
            state_d = hasu_pkg::S_IDLE;
          end else begin
            oc_d = oc_q + IW'(1);
          end
        end
      end
      default: state_d = hasu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hasu_pkg::S_IDLE;
      iss_q     <= 1'b0;
      pv_q      <= 1'b0;
      plast_q   <= 1'b0;
      star_v_q  <= '0;
      prime_v_q <= '0;
      row_cov_q <= '0;
      col_cov_q <= '0;
      m_valid_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      pv_q      <= pv_d;
      plast_q   <= plast_d;
      star_v_q  <= star_v_d;
      prime_v_q <= prime_v_d;
      row_cov_q <= row_cov_d;
      col_cov_q <= col_cov_d;
      m_valid_q <= m_valid_d;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ia_q        <= ia_d;
    ib_q        <= ib_d;
    pr_q        <= pr_d;
    pc_q        <= pc_d;
    mn_q        <= mn_d;
    found_q     <= found_d;
    zhit_q      <= zhit_d;
    zlock_q     <= zlock_d;
    zr_q        <= zr_d;
    zc_q        <= zc_d;
    oc_q        <= oc_d;
    star_col_q  <= star_col_d;
    prime_col_q <= prime_col_d;
    m_last_q    <= m_last_d;
    m_data_q    <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hasu_pkg::S_IDLE) |-> (!iss_q && !pv_q))
    else $error("scan active while idle");

  a_star_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != hasu_pkg::S_IDLE) |-> ($countones(star_v_q) <= int'(need)))
    else $error("more stars than assignable pairs");

  a_solve_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (state_q == hasu_pkg::S_RMIN))
    else $error("final request did not start a solve");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == hasu_pkg::S_EMIT))
    else $error("result raised outside the report phase");

endmodule
`default_nettype wire
